>>> sv/fvae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fvae_pkg;

  // microseconds per second, the scale of both finite differences
  localparam logic [19:0] US_PER_S = 20'd1000000;

  // magnitude operand: |delta| <= 2^31, |dv| < 2^32
  localparam int unsigned MAG_W     = 33;
  // dividend holds magnitude times one million, rounded up to an even width
  localparam int unsigned DIV_W     = 54;
  localparam int unsigned DIV_STEPS = DIV_W / 2;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [31:0] delta;
    logic [31:0]        dt;
    logic               held;
  } item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_DIV,
    B_FIN
  } back_state_e;

endpackage

`default_nettype wire

>>> sv/encoder_velocity_accel_estimator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Encoder velocity and acceleration estimator. Each sample transfer carries a
// raw position and the microseconds since the previous sample; one result
// comes back per sample with velocity (counts/s) and acceleration
// (counts/s^2), both truncated toward zero and saturated to 32-bit signed.
// A nonzero measuring_range enables rollover correction of the position
// difference. Zero elapsed time returns the previous values with held set.
// The front end queues a sample unless the queue is full; the back end
// computes both quotients with one shared restoring divider that retires two
// bits per cycle. Each nonzero-elapsed sample is dequeued, then multiplied,
// divided and finished for velocity and again for acceleration; a new sample
// is taken only after that. Throughput is set by that divider.
// measuring_range should be written while no sample is in flight.

module encoder_velocity_accel_estimator_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [30:0]        measuring_range_i,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic signed [31:0] position_i,
  input  wire logic [31:0]        elapsed_us_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] velocity_o,
  output      logic signed [31:0] acceleration_o,
  output      logic               held_o,
  output      logic               saturated_o
);

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  fvae_pkg::item_t front_item;
  fvae_pkg::item_t head_item;

  assign cfg_ready_o = 1'b1;

  fvae_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .measuring_range_i (measuring_range_i),
    .in_valid_i        (in_valid_i),
    .position_i        (position_i),
    .elapsed_us_i      (elapsed_us_i),
    .full_i            (full),
    .in_stall_o        (in_stall_o),
    .push_o            (push),
    .item_o            (front_item)
  );

  fvae_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .item_o  (head_item)
  );

  fvae_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .item_i         (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .held_o         (held_o),
    .saturated_o    (saturated_o)
  );

endmodule

`default_nettype wire

>>> sv/fvae_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fvae_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [30:0]        measuring_range_i,
  input  wire logic               in_valid_i,
  input  wire logic signed [31:0] position_i,
  input  wire logic [31:0]        elapsed_us_i,
  input  wire logic               full_i,
  output      logic               in_stall_o,
  output      logic               push_o,
  output      fvae_pkg::item_t    item_o
);

  logic [30:0]        range_q;
  logic signed [31:0] last_pos_q;
  logic signed [31:0] raw;
  logic signed [32:0] d33;
  logic signed [32:0] half33;
  logic signed [32:0] range33;
  logic signed [32:0] corr;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    raw     = position_i - last_pos_q;
    d33     = {raw[31], raw};
    half33  = {3'b000, range_q[30:1]};
    range33 = {2'b00, range_q};
    corr    = d33;
    // rollover correction against half the range
    if (range_q != 31'd0) begin
      if (d33 > half33) begin
        corr = d33 - range33;
      end else if (d33 < -half33) begin
        corr = d33 + range33;
      end
    end
    item_o.delta = corr[31:0];
    item_o.dt    = elapsed_us_i;
    item_o.held  = (elapsed_us_i == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q    <= '0;
      last_pos_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        range_q <= measuring_range_i;
      end
      if (push_o) begin
        last_pos_q <= position_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/fvae_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fvae_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire fvae_pkg::item_t item_i,
  input  wire logic            pop_i,
  output      logic            full_o,
  output      logic            empty_o,
  output      fvae_pkg::item_t item_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fvae_pkg::item_t mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q;
  logic [AW-1:0]   rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> sv/fvae_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fvae_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire fvae_pkg::item_t    item_i,
  output      logic               pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] velocity_o,
  output      logic signed [31:0] acceleration_o,
  output      logic               held_o,
  output      logic               saturated_o
);

  localparam int unsigned MW = fvae_pkg::MAG_W;
  localparam int unsigned DW = fvae_pkg::DIV_W;

  fvae_pkg::back_state_e state_q, state_d;

  logic                        phase_q;
  logic [MW-1:0]               mag_q;
  logic                        neg_q;
  logic [31:0]                 dt_q;
  logic [DW-1:0]               div_q;
  logic [31:0]                 rem_q;
  logic [fvae_pkg::CNT_W-1:0]  cnt_q;
  logic signed [31:0]          vel_q;
  logic signed [31:0]          last_vel_q;
  logic signed [31:0]          last_acc_q;
  logic                        sat_q;
  logic                        out_valid_q;
  logic signed [31:0]          out_vel_q;
  logic signed [31:0]          out_acc_q;
  logic                        out_held_q;
  logic                        out_sat_q;

  logic               out_free;
  logic               load_held;
  logic               load_calc;
  logic [DW-1:0]      div_n;
  logic [31:0]        rem_n;
  logic [32:0]        trial;
  logic               clip;
  logic signed [31:0] val;
  logic signed [32:0] dv;
  logic signed [32:0] delta33;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    load_held = 1'b0;
    load_calc = 1'b0;
    unique case (state_q)
      fvae_pkg::B_IDLE: begin
        if (!empty_i) begin
          if (item_i.held) begin
            if (out_free) begin
              pop_o     = 1'b1;
              load_held = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            state_d = fvae_pkg::B_MUL;
          end
        end
      end
      fvae_pkg::B_MUL: begin
        state_d = fvae_pkg::B_DIV;
      end
      fvae_pkg::B_DIV: begin
        if (cnt_q == fvae_pkg::CNT_W'(fvae_pkg::DIV_STEPS - 1)) begin
          state_d = fvae_pkg::B_FIN;
        end
      end
      fvae_pkg::B_FIN: begin
        if (!phase_q) begin
          state_d = fvae_pkg::B_MUL;
        end else if (out_free) begin
          load_calc = 1'b1;
          state_d   = fvae_pkg::B_IDLE;
        end
      end
      default: state_d = fvae_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fvae_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // restoring division, two quotient bits per cycle
  always_comb begin
    rem_n = rem_q;
    div_n = div_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_n, div_n[DW-1]};
      div_n = {div_n[DW-2:0], 1'b0};
      if (trial >= {1'b0, dt_q}) begin
        rem_n    = 32'(trial - {1'b0, dt_q});
        div_n[0] = 1'b1;
      end else begin
        rem_n = trial[31:0];
      end
    end
  end

  // sign the quotient magnitude and clip to 32-bit signed; also form dv and the widened delta
  always_comb begin
    if (!neg_q) begin
      clip = |div_q[DW-1:31];
      val  = clip ? 32'sh7fffffff : div_q[31:0];
    end else begin
      clip = (|div_q[DW-1:32]) || (div_q[31] && (|div_q[30:0]));
      val  = clip ? 32'sh80000000 : 32'd0 - div_q[31:0];
    end
    dv      = {val[31], val} - {last_vel_q[31], last_vel_q};
    delta33 = {item_i.delta[31], item_i.delta};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_vel_q  <= '0;
      last_acc_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_calc) begin
        last_vel_q <= vel_q;
        last_acc_q <= val;
      end
      if (load_held || load_calc) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      fvae_pkg::B_IDLE: begin
        if (pop_o && !item_i.held) begin
          phase_q <= 1'b0;
          neg_q   <= item_i.delta[31];
          mag_q   <= item_i.delta[31] ? MW'(-delta33) : MW'(delta33);
          dt_q    <= item_i.dt;
        end
      end
      fvae_pkg::B_MUL: begin
        div_q <= DW'(mag_q * fvae_pkg::US_PER_S);
        rem_q <= '0;
        cnt_q <= '0;
      end
      fvae_pkg::B_DIV: begin
        div_q <= div_n;
        rem_q <= rem_n;
        cnt_q <= cnt_q + 1'b1;
      end
      fvae_pkg::B_FIN: begin
        if (!phase_q) begin
          // velocity done, set up the acceleration quotient
          vel_q   <= val;
          sat_q   <= clip;
          phase_q <= 1'b1;
          neg_q   <= dv[32];
          mag_q   <= dv[32] ? MW'(-dv) : MW'(dv);
        end
      end
      default: ;
    endcase
    if (load_held) begin
      out_vel_q  <= last_vel_q;
      out_acc_q  <= last_acc_q;
      out_held_q <= 1'b1;
      out_sat_q  <= 1'b0;
    end else if (load_calc) begin
      out_vel_q  <= vel_q;
      out_acc_q  <= val;
      out_held_q <= 1'b0;
      out_sat_q  <= sat_q || clip;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign velocity_o     = out_vel_q;
  assign acceleration_o = out_acc_q;
  assign held_o         = out_held_q;
  assign saturated_o    = out_sat_q;

  a_dt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fvae_pkg::B_DIV |-> dt_q != 32'd0)
    else $error("division by zero elapsed time");

  a_held_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_held_q |-> !out_sat_q)
    else $error("held result flagged saturated");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(load_held || load_calc))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
